// File: design/ewm_pkg.sv
`default_nettype none
package ewm_pkg;

  localparam int MEMORY_DEPTH   = 65536;
  localparam int REGISTER_COUNT = 8;

  localparam int MEM_AW = $clog2(MEMORY_DEPTH);
  localparam int REG_AW = $clog2(REGISTER_COUNT);

  // Upper bound for address checks, one bit wider than any 16-bit address.
  localparam logic [16:0] MEM_LIMIT = 17'(MEMORY_DEPTH);

  // Request operations.
  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_EXEC     = 2'd1,
    CMD_READ_MEM = 2'd2,
    CMD_READ_REG = 2'd3
  } cmd_t;

  // Instruction opcodes, bits 24..22 of the instruction word.
  typedef enum logic [2:0] {
    INS_ADD  = 3'd0,
    INS_NOR  = 3'd1,
    INS_LW   = 3'd2,
    INS_SW   = 3'd3,
    INS_BEQ  = 3'd4,
    INS_JALR = 3'd5,
    INS_HALT = 3'd6,
    INS_NOOP = 3'd7
  } ins_op_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_HALTED     = 3'd1,
    STAT_STOPPED    = 3'd2,
    STAT_PC_RANGE   = 3'd3,
    STAT_DATA_RANGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MEM_RD,
    S_REG_RD,
    S_FETCH,
    S_READ_A,
    S_EXEC,
    S_LW_WAIT
  } state_t;

endpackage
`default_nettype wire

// File: design/ewm_ram.sv
`default_nettype none
module ewm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/eight_op_word_machine_core.sv
`default_nettype none
// Eight-opcode word machine core. A request (start high while busy is low) loads a memory
// word, executes one instruction, reads a memory word or reads a register, and each request
// gives exactly one result, shown for one cycle while done is high; the receiver cannot
// stall it, so it must take every result in that cycle. After reset the block clears
// every memory word and register, with busy held high. A load, an out-of-range read or an
// execute that faults at once (stopped, or pc out of range) is answered from the idle state;
// a memory or register read goes through a read state; an instruction runs in steps set by
// the single read port of the main memory and of the register file: fetch, read regA, read
// regB and execute, then the lw data read. A new request may be made in the cycle that done is high.
module eight_op_word_machine_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode,
  input  wire logic [15:0]        address,
  input  wire logic signed [31:0] load_data,
  output logic                    done,
  output logic [15:0]             program_counter,
  output logic [2:0]              status,
  output logic signed [31:0]      read_data,
  output logic [31:0]             executed_count
);

  import ewm_pkg::*;

  // Machine state.
  state_t               state, state_next;
  logic [MEM_AW-1:0]    clear_addr, clear_addr_next;
  logic [15:0]          pc, pc_next;
  logic                 stopped, stopped_next;
  logic [31:0]          count, count_next;
  logic [31:0]          instr, instr_next;
  logic [31:0]          va, va_next;

  // Result registers.
  logic                 done_next;
  status_t              status_next;
  logic [31:0]          read_data_next;

  // Memory ports.
  logic                 mem_we;
  logic [MEM_AW-1:0]    mem_waddr, mem_raddr;
  logic [31:0]          mem_wdata, mem_rdata;
  logic                 rf_we;
  logic [REG_AW-1:0]    rf_waddr, rf_raddr;
  logic [31:0]          rf_wdata, rf_rdata;

  // Decode of the latched instruction.
  ins_op_t              ins_op;
  logic [REG_AW-1:0]    ra, rb, rd;
  logic [32:0]          off_ext, va_ext;
  logic [32:0]          ls_addr, next_pc;
  logic [16:0]          pc_inc;
  logic                 ls_ok, next_ok, addr_ok;

  ewm_ram #(.WIDTH(32), .DEPTH(MEMORY_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ewm_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  assign busy            = (state != S_IDLE);
  assign program_counter = pc;
  assign executed_count  = count;

  assign ins_op  = ins_op_t'(instr[24:22]);
  assign ra      = instr[21:19];
  assign rb      = instr[18:16];
  assign rd      = instr[2:0];
  assign off_ext = {{17{instr[15]}}, instr[15:0]};
  assign va_ext  = {va[31], va};
  assign pc_inc  = {1'b0, pc} + 17'd1;
  assign addr_ok = ({1'b0, address} < MEM_LIMIT);

  // Data address of lw and sw: regA as a signed word plus the signed offset.
  assign ls_addr = va_ext + off_ext;
  assign ls_ok   = !ls_addr[32] && (ls_addr < 33'(MEMORY_DEPTH));

  // The next pc for every instruction that checks it; rf_rdata holds regB in S_EXEC.
  always_comb begin
    next_pc = {16'd0, pc_inc};
    if (ins_op == INS_BEQ && va == rf_rdata) begin
      next_pc = {16'd0, pc_inc} + off_ext;
    end else if (ins_op == INS_JALR && ra != rb) begin
      // When regA is regB the link write wins and the jump goes to pc+1.
      next_pc = va_ext;
    end
  end
  assign next_ok = !next_pc[32] && (next_pc < 33'(MEMORY_DEPTH));

  always_comb begin
    state_next      = state;
    clear_addr_next = clear_addr;
    pc_next         = pc;
    stopped_next    = stopped;
    count_next      = count;
    instr_next      = instr;
    va_next         = va;
    done_next       = 1'b0;
    status_next     = STAT_OK;
    read_data_next  = read_data;

    mem_we    = 1'b0;
    mem_waddr = address[MEM_AW-1:0];
    mem_wdata = load_data;
    mem_raddr = address[MEM_AW-1:0];
    rf_we     = 1'b0;
    rf_waddr  = rd;
    rf_wdata  = 32'd0;
    rf_raddr  = address[REG_AW-1:0];

    unique case (state)
      S_CLEAR: begin
        // Sweep zeros through both memories; the register file wraps over its entries.
        mem_we    = 1'b1;
        mem_waddr = clear_addr;
        mem_wdata = 32'd0;
        rf_we     = 1'b1;
        rf_waddr  = clear_addr[REG_AW-1:0];
        clear_addr_next = clear_addr + MEM_AW'(1);
        if (clear_addr == MEM_AW'(MEMORY_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          read_data_next = 32'd0;
          unique case (cmd_t'(opcode))
            CMD_LOAD: begin
              done_next = 1'b1;
              if (addr_ok) begin
                mem_we = 1'b1;
              end else begin
                status_next = STAT_DATA_RANGE;
              end
            end
            CMD_READ_MEM: begin
              if (addr_ok) begin
                state_next = S_MEM_RD;
              end else begin
                done_next   = 1'b1;
                status_next = STAT_DATA_RANGE;
              end
            end
            CMD_READ_REG: begin
              state_next = S_REG_RD;
            end
            CMD_EXEC: begin
              mem_raddr = pc[MEM_AW-1:0];
              if (stopped) begin
                done_next   = 1'b1;
                status_next = STAT_STOPPED;
              end else if ({1'b0, pc} >= MEM_LIMIT) begin
                // The fault is uncounted; a 16-bit pc never reaches MEM_LIMIT, since a halt wraps it to zero.
                done_next    = 1'b1;
                stopped_next = 1'b1;
                status_next  = STAT_PC_RANGE;
              end else begin
                state_next = S_FETCH;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_MEM_RD: begin
        done_next      = 1'b1;
        read_data_next = mem_rdata;
        state_next     = S_IDLE;
      end

      S_REG_RD: begin
        done_next      = 1'b1;
        read_data_next = rf_rdata;
        state_next     = S_IDLE;
      end

      S_FETCH: begin
        instr_next = mem_rdata;
        rf_raddr   = mem_rdata[21:19];
        state_next = S_READ_A;
      end

      S_READ_A: begin
        va_next    = rf_rdata;
        rf_raddr   = rb;
        state_next = S_EXEC;
      end

      S_EXEC: begin
        // The instruction is counted here whatever its outcome.
        if (count != 32'hFFFF_FFFF) begin
          count_next = count + 32'd1;
        end
        mem_raddr  = ls_addr[MEM_AW-1:0];
        mem_waddr  = ls_addr[MEM_AW-1:0];
        mem_wdata  = rf_rdata;
        state_next = S_IDLE;
        done_next  = 1'b1;
        unique case (ins_op)
          INS_ADD: begin
            rf_we    = 1'b1;
            rf_wdata = va + rf_rdata;
          end
          INS_NOR: begin
            rf_we    = 1'b1;
            rf_wdata = ~(va | rf_rdata);
          end
          INS_LW: begin
            if (ls_ok) begin
              done_next  = 1'b0;
              state_next = S_LW_WAIT;
            end
          end
          INS_SW: begin
            mem_we = ls_ok;
          end
          INS_JALR: begin
            rf_we    = 1'b1;
            rf_waddr = rb;
            rf_wdata = {15'd0, pc_inc};
          end
          INS_BEQ, INS_HALT, INS_NOOP: begin
            rf_we = 1'b0;
          end
          default: begin
            rf_we = 1'b0;
          end
        endcase

        if ((ins_op == INS_LW || ins_op == INS_SW) && !ls_ok) begin
          // Data address fault: nothing is written and the pc stays.
          stopped_next = 1'b1;
          status_next  = STAT_DATA_RANGE;
        end else if (ins_op == INS_HALT) begin
          pc_next      = pc_inc[15:0];
          stopped_next = 1'b1;
          status_next  = STAT_HALTED;
        end else if (ins_op != INS_LW) begin
          if (next_ok) begin
            pc_next = next_pc[15:0];
          end else begin
            stopped_next = 1'b1;
            status_next  = STAT_PC_RANGE;
          end
        end
      end

      S_LW_WAIT: begin
        rf_we      = 1'b1;
        rf_waddr   = rb;
        rf_wdata   = mem_rdata;
        done_next  = 1'b1;
        state_next = S_IDLE;
        // lw never jumps, so only pc+1 needs checking.
        if (pc_inc < MEM_LIMIT) begin
          pc_next = pc_inc[15:0];
        end else begin
          stopped_next = 1'b1;
          status_next  = STAT_PC_RANGE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      pc         <= 16'd0;
      stopped    <= 1'b0;
      count      <= 32'd0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      clear_addr <= clear_addr_next;
      pc         <= pc_next;
      stopped    <= stopped_next;
      count      <= count_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    instr     <= instr_next;
    va        <= va_next;
    status    <= status_next;
    read_data <= read_data_next;
  end

endmodule
`default_nettype wire
